// File: rtl/bts_pkg.sv
// Shared types and constants of the block tuple sorter.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package bts_pkg;

   localparam int WORD_W  = 64;   // width of one tuple column
   localparam int IO_COLS = 4;    // columns carried on the ports
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 3;
   localparam int CCNT_W  = 3;    // width of the column count register
   localparam int DEST_W  = 2;    // width of a column map entry

   typedef logic [WORD_W-1:0] word_type;

   // Request function codes.
   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_READ   = 1'b1
   } func_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_INSERTED  = 2'd0,
      STATUS_DROPPED   = 2'd1,
      STATUS_TUPLE_OUT = 2'd2,
      STATUS_EMPTY     = 2'd3
   } status_type;

   // Configuration register indices.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COLUMN_COUNT = 3'd0,
      CSR_DEST_COL0    = 3'd1,
      CSR_DEST_COL1    = 3'd2,
      CSR_DEST_COL2    = 3'd3,
      CSR_DEST_COL3    = 3'd4
   } csr_index_type;

   // Operation broadcast to every cell of the row for one cycle.
   typedef struct packed {
      logic insert;   // place the key, shifting larger tuples up
      logic pop;      // drop cell 0 and shift every tuple down
   } cell_ctl_type;

endpackage : bts_pkg

`default_nettype wire

// File: rtl/bts_keymap.sv
// Column map of the block tuple sorter: permutes an incoming tuple into
// its stored column order. Depends on bts_pkg.
`default_nettype none

module bts_keymap #(
   parameter int MAX_COLUMNS = 4
) (
   input  bts_pkg::word_type                       in_col   [bts_pkg::IO_COLS],
   input  logic [bts_pkg::CCNT_W-1:0]              column_count,
   input  logic [bts_pkg::DEST_W-1:0]              dest_of_col [bts_pkg::IO_COLS],
   output logic [MAX_COLUMNS-1:0][bts_pkg::WORD_W-1:0] key
);
   import bts_pkg::*;

   localparam int LIM = (MAX_COLUMNS < IO_COLS) ? MAX_COLUMNS : IO_COLS;

   logic [CCNT_W-1:0] eff_cols;

   // Column count of zero acts as one, and it saturates at the column limit.
   always_comb begin
      if (column_count == '0) begin
         eff_cols = CCNT_W'(1);
      end else if (column_count > CCNT_W'(LIM)) begin
         eff_cols = CCNT_W'(LIM);
      end else begin
         eff_cols = column_count;
      end
   end

   // Later input columns override earlier ones aimed at the same position.
   always_comb begin
      key = '0;
      for (int p = 0; p < MAX_COLUMNS; p++) begin
         for (int n = 0; n < IO_COLS; n++) begin
            if (p < IO_COLS && CCNT_W'(p) < eff_cols && CCNT_W'(n) < eff_cols &&
                dest_of_col[n] == DEST_W'(p)) begin
               key[p] = in_col[n];
            end
         end
      end
   end

endmodule : bts_keymap

`default_nettype wire

// File: rtl/bts_cell.sv
// One cell of the sorting row: holds a single tuple, compares it with the
// key and takes its neighbour's tuple on a shift. Depends on bts_pkg.
`default_nettype none

module bts_cell #(
   parameter int MAX_COLUMNS = 4,
   parameter int CNT_W       = 10,
   parameter int INDEX       = 0
) (
   input  logic                                         clock,
   input  bts_pkg::cell_ctl_type                        ctl,
   input  logic [CNT_W-1:0]                             count,
   input  logic [MAX_COLUMNS-1:0][bts_pkg::WORD_W-1:0]  key,
   input  logic [MAX_COLUMNS-1:0][bts_pkg::WORD_W-1:0]  tuple_prev,
   input  logic                                         lt_prev,
   input  logic [MAX_COLUMNS-1:0][bts_pkg::WORD_W-1:0]  tuple_next,
   output logic [MAX_COLUMNS-1:0][bts_pkg::WORD_W-1:0]  tuple_out,
   output logic                                         lt_out
);
   import bts_pkg::*;

   localparam int FLAT_W = MAX_COLUMNS * WORD_W;

   logic [MAX_COLUMNS-1:0][WORD_W-1:0] tuple_ff, tuple_in;
   logic [FLAT_W-1:0]                  key_flat, own_flat;
   logic                               occupied, at_count;

   assign occupied = (count > CNT_W'(INDEX));
   assign at_count = (count == CNT_W'(INDEX));

   // Column 0 is the most significant part of the comparison.
   always_comb begin
      for (int c = 0; c < MAX_COLUMNS; c++) begin
         key_flat[(MAX_COLUMNS-1-c)*WORD_W +: WORD_W] = key[c];
         own_flat[(MAX_COLUMNS-1-c)*WORD_W +: WORD_W] = tuple_ff[c];
      end
   end

   assign lt_out = occupied && (key_flat < own_flat);

   always_comb begin
      tuple_in = tuple_ff;
      if (ctl.insert && (lt_out || at_count)) begin
         tuple_in = lt_prev ? tuple_prev : key;
      end else if (ctl.pop) begin
         tuple_in = tuple_next;
      end
   end

   always_ff @(posedge clock) begin
      tuple_ff <= tuple_in;
   end

   assign tuple_out = tuple_ff;

endmodule : bts_cell

`default_nettype wire

// File: rtl/block_tuple_sorter.sv
// Top level of the block tuple sorter: column map, row of sorting cells,
// fill count, result register and configuration registers. Depends on
// bts_pkg, bts_keymap and bts_cell.
//
//   Channel   Direction   Handshake              Beat carries
//   req_      in          req_valid / req_stall  func and four input columns
//   rsp_      out         rsp_valid / rsp_stall  status, four columns, last flag
//   csr_      in          csr_valid / csr_ready  register index and write data
//
// One request is taken in every cycle unless a response beat is stalled; its
// result is in the response register the next cycle. The row compares all
// held tuples with the key and shifts in the same cycle, so it sets the rate.
// Reset clears the fill count and the response valid and loads the
// configuration registers with their reset values; the cells need no
// clearing, as only filled cells are read.
// A stalled response beat stalls the request side in the same cycle.
`default_nettype none

module block_tuple_sorter #(
   parameter int BLOCK_TUPLES = 512,
   parameter int MAX_COLUMNS  = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_func,
   input  bts_pkg::word_type                 req_in_col0,
   input  bts_pkg::word_type                 req_in_col1,
   input  bts_pkg::word_type                 req_in_col2,
   input  bts_pkg::word_type                 req_in_col3,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output bts_pkg::word_type                 rsp_out_col0,
   output bts_pkg::word_type                 rsp_out_col1,
   output bts_pkg::word_type                 rsp_out_col2,
   output bts_pkg::word_type                 rsp_out_col3,
   output logic                              rsp_last_of_block,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bts_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bts_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bts_pkg::*;

   localparam int CNT_W = $clog2(BLOCK_TUPLES + 1);

   typedef logic [MAX_COLUMNS-1:0][WORD_W-1:0] tuple_type;

   // Configuration registers.
   logic [CCNT_W-1:0] colcnt_ff, colcnt_in;
   logic [DEST_W-1:0] dest_ff [IO_COLS];
   logic [DEST_W-1:0] dest_in [IO_COLS];

   // Fill count and response register.
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       status_ff, status_in;
   word_type         out_ff [IO_COLS];
   word_type         out_in [IO_COLS];
   logic             last_ff, last_in;

   logic         in_fire, is_read, full, empty;
   word_type     in_cols [IO_COLS];
   tuple_type    key;
   tuple_type    tup [BLOCK_TUPLES];
   logic         lt  [BLOCK_TUPLES];
   cell_ctl_type ctl;

   // ---------------------------------------------------------------
   // Handshakes. The response register is the only buffer, so a request
   // waits only while a finished beat is held back by the consumer.
   // ---------------------------------------------------------------
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign in_fire   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign is_read = (req_func == FUNC_READ);
   assign full    = (count_ff == CNT_W'(BLOCK_TUPLES));
   assign empty   = (count_ff == '0);

   // ---------------------------------------------------------------
   // Configuration writes. Indices past the register list are ignored.
   // ---------------------------------------------------------------
   always_comb begin
      colcnt_in = colcnt_ff;
      dest_in   = dest_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_COLUMN_COUNT: colcnt_in  = csr_wdata;
            CSR_DEST_COL0:    dest_in[0] = csr_wdata[DEST_W-1:0];
            CSR_DEST_COL1:    dest_in[1] = csr_wdata[DEST_W-1:0];
            CSR_DEST_COL2:    dest_in[2] = csr_wdata[DEST_W-1:0];
            CSR_DEST_COL3:    dest_in[3] = csr_wdata[DEST_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // The incoming tuple is permuted into stored column order first.
   // ---------------------------------------------------------------
   assign in_cols[0] = req_in_col0;
   assign in_cols[1] = req_in_col1;
   assign in_cols[2] = req_in_col2;
   assign in_cols[3] = req_in_col3;

   bts_keymap #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_keymap (
      .in_col       (in_cols),
      .column_count (colcnt_ff),
      .dest_of_col  (dest_ff),
      .key          (key)
   );

   // ---------------------------------------------------------------
   // Row of cells. Cell 0 holds the smallest tuple. On an insert, each
   // cell whose tuple is larger than the key takes its lower neighbour's
   // tuple, and the first of them (or the first empty cell) takes the key,
   // which keeps equal tuples in arrival order. On a read, every cell
   // takes its upper neighbour's tuple.
   // ---------------------------------------------------------------
   assign ctl = '{insert: in_fire && !is_read && !full,
                  pop:    in_fire && is_read && !empty};

   for (genvar i = 0; i < BLOCK_TUPLES; i++) begin : g_cell
      tuple_type prev_t, next_t;
      logic      prev_lt;

      if (i == 0) begin : g_first
         assign prev_t  = key;
         assign prev_lt = 1'b0;
      end else begin : g_mid
         assign prev_t  = tup[i-1];
         assign prev_lt = lt[i-1];
      end

      if (i == BLOCK_TUPLES - 1) begin : g_last
         assign next_t = tup[i];
      end else begin : g_inner
         assign next_t = tup[i+1];
      end

      bts_cell #(
         .MAX_COLUMNS (MAX_COLUMNS),
         .CNT_W       (CNT_W),
         .INDEX       (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .count      (count_ff),
         .key        (key),
         .tuple_prev (prev_t),
         .lt_prev    (prev_lt),
         .tuple_next (next_t),
         .tuple_out  (tup[i]),
         .lt_out     (lt[i])
      );
   end

   // ---------------------------------------------------------------
   // Fill count and the next response beat.
   // ---------------------------------------------------------------
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      out_in       = out_ff;
      last_in      = last_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (in_fire) begin
         rsp_valid_in = 1'b1;
         last_in      = 1'b0;
         for (int n = 0; n < IO_COLS; n++) begin
            out_in[n] = '0;
         end
         if (!is_read) begin
            if (full) begin
               status_in = STATUS_DROPPED;
            end else begin
               status_in = STATUS_INSERTED;
               count_in  = count_ff + CNT_W'(1);
            end
         end else if (empty) begin
            status_in = STATUS_EMPTY;
         end else begin
            status_in = STATUS_TUPLE_OUT;
            count_in  = count_ff - CNT_W'(1);
            last_in   = (count_ff == CNT_W'(1));
            for (int n = 0; n < IO_COLS; n++) begin
               if (n < MAX_COLUMNS) begin
                  out_in[n] = tup[0][n];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         colcnt_ff    <= CCNT_W'(IO_COLS);
         for (int n = 0; n < IO_COLS; n++) begin
            dest_ff[n] <= DEST_W'(n);
         end
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         colcnt_ff    <= colcnt_in;
         dest_ff      <= dest_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      out_ff    <= out_in;
      last_ff   <= last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_out_col0      = out_ff[0];
   assign rsp_out_col1      = out_ff[1];
   assign rsp_out_col2      = out_ff[2];
   assign rsp_out_col3      = out_ff[3];
   assign rsp_last_of_block = last_ff;

endmodule : block_tuple_sorter

`default_nettype wire

// File: rtl/bts_checker.sv
// Port-level checks of the block tuple sorter, bound to its top level.
// Depends on bts_pkg and block_tuple_sorter.
`default_nettype none

module bts_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [1:0]        rsp_status,
   input bts_pkg::word_type rsp_out_col0,
   input bts_pkg::word_type rsp_out_col1,
   input bts_pkg::word_type rsp_out_col2,
   input bts_pkg::word_type rsp_out_col3,
   input logic              rsp_last_of_block
);
   import bts_pkg::*;

   // A stalled response beat stays and holds its status, first column and last flag.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_out_col0) && $stable(rsp_last_of_block))
      else $error("stalled response beat changed");

   // Requests are held back only while a response beat is held back.
   a_stall_src: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled response");

   // Only a read that returns a tuple may flag the end of the block.
   a_last_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_block |-> rsp_status == STATUS_TUPLE_OUT)
      else $error("last flag on a beat without a tuple");

   // Beats without a tuple carry zero columns.
   a_zero_cols: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_TUPLE_OUT |->
      rsp_out_col0 == '0 && rsp_out_col1 == '0 &&
      rsp_out_col2 == '0 && rsp_out_col3 == '0)
      else $error("non-read beat carries tuple data");

   // Each accepted request gives a response beat in the next cycle.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request gave no response beat");

endmodule : bts_checker

bind block_tuple_sorter bts_checker u_bts_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_out_col0      (rsp_out_col0),
   .rsp_out_col1      (rsp_out_col1),
   .rsp_out_col2      (rsp_out_col2),
   .rsp_out_col3      (rsp_out_col3),
   .rsp_last_of_block (rsp_last_of_block)
);

`default_nettype wire
